### sv/lpvt_pkg.sv
// ----------------------------------------------------------------------------
// lpvt_pkg: shared types and constants of the link probe verdict table
// Holds the register map, the request and response codes, the register set
// and the response bundle that travel between the blocks of the table.
// ----------------------------------------------------------------------------
package lpvt_pkg;

   // Field widths fixed by the request and response formats
   localparam int unsigned TIME_W       = 48;
   localparam int unsigned INDEX_W      = 4;
   localparam int unsigned CODE_W       = 2;
   localparam int unsigned CAUSE_W      = 3;
   localparam int unsigned SECONDS_W    = 16;
   localparam int unsigned THRESHOLD_W  = 8;
   localparam int unsigned CSR_INDEX_W  = 3;
   localparam int unsigned CSR_DATA_W   = 16;

   // Seconds to milliseconds
   localparam int unsigned MS_PER_SECOND = 1000;
   localparam int unsigned MS_W          = SECONDS_W + 10;

   // Parameter defaults
   localparam int unsigned ENTRIES_DEFAULT   = 16;
   localparam int unsigned RUN_WIDTH_DEFAULT = 8;

   // Register map
   localparam logic [CSR_INDEX_W-1:0] CSR_INTERVAL_SECONDS  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_UP_THRESHOLD      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DOWN_THRESHOLD    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOLD_DOWN_SECONDS = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_LEASE_REQUIRED    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_FAIL_LIMIT  = 3'd5;

   // Register reset values
   localparam logic [SECONDS_W-1:0]   RST_INTERVAL_SECONDS  = 16'd10;
   localparam logic [THRESHOLD_W-1:0] RST_UP_THRESHOLD      = 8'd1;
   localparam logic [THRESHOLD_W-1:0] RST_DOWN_THRESHOLD    = 8'd1;
   localparam logic [SECONDS_W-1:0]   RST_HOLD_DOWN_SECONDS = 16'd0;
   localparam logic                   RST_LEASE_REQUIRED    = 1'b0;
   localparam logic [THRESHOLD_W-1:0] RST_START_FAIL_LIMIT  = 8'd3;

   // Request opcodes
   localparam logic OP_PROBE  = 1'b0;
   localparam logic OP_FORGET = 1'b1;

   // Probe result codes
   localparam logic [CODE_W-1:0] RC_OK          = 2'd0;
   localparam logic [CODE_W-1:0] RC_FAILED      = 2'd1;
   localparam logic [CODE_W-1:0] RC_NOT_STARTED = 2'd2;

   // Response causes
   localparam logic [CAUSE_W-1:0] CAUSE_OK          = 3'd0;
   localparam logic [CAUSE_W-1:0] CAUSE_FAILED      = 3'd1;
   localparam logic [CAUSE_W-1:0] CAUSE_NO_LEASE    = 3'd2;
   localparam logic [CAUSE_W-1:0] CAUSE_NOT_STARTED = 3'd3;
   localparam logic [CAUSE_W-1:0] CAUSE_SKIPPED     = 3'd4;

   // Shared policy registers
   typedef struct packed {
      logic [SECONDS_W-1:0]   interval_seconds;
      logic [THRESHOLD_W-1:0] up_threshold;
      logic [THRESHOLD_W-1:0] down_threshold;
      logic [SECONDS_W-1:0]   hold_down_seconds;
      logic                   lease_required;
      logic [THRESHOLD_W-1:0] start_fail_limit;
   } lpvt_cfg_type;

   // Single-bit state of one table entry
   typedef struct packed {
      logic present;
      logic verdict_has;
      logic verdict_val;
      logic due_armed;
      logic dwell_armed;
      logic aside;
   } lpvt_flags_type;

   localparam int unsigned FLAGS_W = $bits(lpvt_flags_type);

   // One response
   typedef struct packed {
      logic               accepted;
      logic [CAUSE_W-1:0] cause;
      logic               verdict_known;
      logic               verdict_up;
      logic               changed;
      logic               is_set_aside;
   } lpvt_rsp_type;

endpackage

### sv/link_probe_verdict_table.sv
// ----------------------------------------------------------------------------
// link_probe_verdict_table: per-link reachability verdicts with hold-down
// Every request is handled as a read and an update: the entry is read from
// the table memory in the cycle the request is taken, and updated and
// written back in the next, so busy is high for one cycle after each start
// and a new request is taken only while busy is low. The response appears
// on the rsp_ ports for exactly one cycle, marked by rsp_strobe, in the
// cycle after the update cycle; the receiver cannot stall it and must
// capture it then. After reset the table reads as all clear at once. The
// user must write the policy registers on the csr_ port, which is always
// ready, only while no request is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module link_probe_verdict_table #(
   parameter int unsigned ENTRIES   = lpvt_pkg::ENTRIES_DEFAULT,
   parameter int unsigned RUN_WIDTH = lpvt_pkg::RUN_WIDTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   // Request channel
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_opcode,
   input  logic [lpvt_pkg::INDEX_W-1:0]     req_entry_index,
   input  logic [lpvt_pkg::TIME_W-1:0]      req_now_ms,
   input  logic [lpvt_pkg::CODE_W-1:0]      req_result_code,
   input  logic                             req_dhcp_mode,
   input  logic                             req_has_lease,
   // Response channel
   output logic                             rsp_strobe,
   output logic                             rsp_accepted,
   output logic [lpvt_pkg::CAUSE_W-1:0]     rsp_cause,
   output logic                             rsp_verdict_known,
   output logic                             rsp_verdict_up,
   output logic                             rsp_changed,
   output logic                             rsp_is_set_aside,
   // Register write channel
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [lpvt_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [lpvt_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import lpvt_pkg::*;

   localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int unsigned EXT_W = IDX_W + INDEX_W;
   localparam int unsigned REC_W = FLAGS_W + 2 * TIME_W + 3 * RUN_WIDTH;
   localparam int unsigned CNT_W = 10;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   state_type            state_ff, state_in;
   logic                 take;

   // Request capture
   logic                 op_ff;
   logic [INDEX_W-1:0]   idx_ff;
   logic [TIME_W-1:0]    now_ff;
   logic [CODE_W-1:0]    code_ff;
   logic                 wants_ff, lease_ff;
   logic [TIME_W-1:0]    due_sum_ff, due_sum_in;
   logic [TIME_W-1:0]    dwell_sum_ff, dwell_sum_in;

   // Response register
   logic                 strobe_ff, strobe_in;
   lpvt_rsp_type         rsp_ff;

   // Block connections
   lpvt_cfg_type         cfg;
   logic [MS_W-1:0]      interval_ms, hold_ms;
   logic [EXT_W-1:0]     rd_idx_ext, wr_idx_ext;
   logic [REC_W-1:0]     rd_rec, wr_rec;
   logic                 upd_wr_en, in_range;
   lpvt_rsp_type         upd_rsp;

   // Saturating time sum
   function automatic logic [TIME_W-1:0] time_after(
      input logic [TIME_W-1:0] now,
      input logic [MS_W-1:0]   ms
   );
      logic [TIME_W:0] sum;
      sum = {1'b0, now} + (TIME_W + 1)'(ms);
      return sum[TIME_W] ? '1 : sum[TIME_W-1:0];
   endfunction

   assign take      = start && !busy;
   assign busy      = (state_ff == ST_EXEC);
   assign csr_ready = 1'b1;

   // Policy registers
   lpvt_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .wr_en       (csr_valid && csr_ready),
      .wr_index    (csr_index),
      .wr_data     (csr_wdata),
      .cfg         (cfg),
      .interval_ms (interval_ms),
      .hold_ms     (hold_ms)
   );

   // Entry store
   assign rd_idx_ext = EXT_W'(req_entry_index);
   assign wr_idx_ext = EXT_W'(idx_ff);
   assign in_range   = (CNT_W'(idx_ff) < CNT_W'(ENTRIES));

   lpvt_table #(
      .ENTRIES (ENTRIES),
      .IDX_W   (IDX_W),
      .REC_W   (REC_W)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (take),
      .rd_addr (rd_idx_ext[IDX_W-1:0]),
      .rd_data (rd_rec),
      .wr_en   (busy && upd_wr_en),
      .wr_addr (wr_idx_ext[IDX_W-1:0]),
      .wr_data (wr_rec)
   );

   // Entry update
   lpvt_update #(
      .RUN_WIDTH (RUN_WIDTH),
      .REC_W     (REC_W)
   ) u_update (
      .in_range    (in_range),
      .opcode      (op_ff),
      .now_ms      (now_ff),
      .result_code (code_ff),
      .dhcp_mode   (wants_ff),
      .has_lease   (lease_ff),
      .due_sum     (due_sum_ff),
      .dwell_sum   (dwell_sum_ff),
      .cfg         (cfg),
      .rd_rec      (rd_rec),
      .wr_en       (upd_wr_en),
      .wr_rec      (wr_rec),
      .rsp         (upd_rsp)
   );

   // Sequence: idle, then the update state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (take) begin
            state_in = ST_EXEC;
         end
         ST_EXEC: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   assign strobe_in    = busy;
   assign due_sum_in   = time_after(req_now_ms, interval_ms);
   assign dwell_sum_in = time_after(req_now_ms, hold_ms);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   // Hold the request and its deadlines
   always_ff @(posedge clock) begin
      if (take) begin
         op_ff        <= req_opcode;
         idx_ff       <= req_entry_index;
         now_ff       <= req_now_ms;
         code_ff      <= req_result_code;
         wants_ff     <= req_dhcp_mode;
         lease_ff     <= req_has_lease;
         due_sum_ff   <= due_sum_in;
         dwell_sum_ff <= dwell_sum_in;
      end
   end

   // Register the response
   always_ff @(posedge clock) begin
      if (busy) begin
         rsp_ff <= upd_rsp;
      end
   end

   assign rsp_strobe        = strobe_ff;
   assign rsp_accepted      = rsp_ff.accepted;
   assign rsp_cause         = rsp_ff.cause;
   assign rsp_verdict_known = rsp_ff.verdict_known;
   assign rsp_verdict_up    = rsp_ff.verdict_up;
   assign rsp_changed       = rsp_ff.changed;
   assign rsp_is_set_aside  = rsp_ff.is_set_aside;

   // Update cycle lasts exactly one clock
   a_exec_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC) |=> (state_ff == ST_IDLE))
      else $error("update cycle did not end");

   // A response follows each update cycle and nothing else
   a_strobe_after_exec: assert property (@(posedge clock) disable iff (reset)
      busy |=> rsp_strobe)
      else $error("response missing after update");

   // A taken result never reports a skip
   a_accepted_cause: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_accepted) |-> (rsp_cause != CAUSE_SKIPPED))
      else $error("taken result reported as skipped");

   // An entry only becomes set aside through a start failure
   a_aside_cause: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_accepted && rsp_is_set_aside) |->
      (rsp_cause == CAUSE_NOT_STARTED))
      else $error("set aside without start failure");

   // A verdict of up implies a known verdict
   a_verdict_known: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_verdict_up) |-> rsp_verdict_known)
      else $error("verdict up without known verdict");

endmodule

### sv/lpvt_csr.sv
// ----------------------------------------------------------------------------
// lpvt_csr: policy register set
// Holds the six shared policy registers and keeps the interval and hold-down
// times converted to milliseconds in registers of their own.
// ----------------------------------------------------------------------------
module lpvt_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             wr_en,
   input  logic [lpvt_pkg::CSR_INDEX_W-1:0] wr_index,
   input  logic [lpvt_pkg::CSR_DATA_W-1:0]  wr_data,
   output lpvt_pkg::lpvt_cfg_type           cfg,
   output logic [lpvt_pkg::MS_W-1:0]        interval_ms,
   output logic [lpvt_pkg::MS_W-1:0]        hold_ms
);
   import lpvt_pkg::*;

   lpvt_cfg_type     cfg_ff, cfg_in;
   logic [MS_W-1:0]  interval_ms_ff, interval_ms_in;
   logic [MS_W-1:0]  hold_ms_ff, hold_ms_in;

   // Decode a register write
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (wr_index)
            CSR_INTERVAL_SECONDS:  cfg_in.interval_seconds  = wr_data;
            CSR_UP_THRESHOLD:      cfg_in.up_threshold      = wr_data[THRESHOLD_W-1:0];
            CSR_DOWN_THRESHOLD:    cfg_in.down_threshold    = wr_data[THRESHOLD_W-1:0];
            CSR_HOLD_DOWN_SECONDS: cfg_in.hold_down_seconds = wr_data;
            CSR_LEASE_REQUIRED:    cfg_in.lease_required    = wr_data[0];
            CSR_START_FAIL_LIMIT:  cfg_in.start_fail_limit  = wr_data[THRESHOLD_W-1:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   // Convert seconds to milliseconds from the next register value, so the
   // millisecond copies change at the same edge as the seconds
   assign interval_ms_in = MS_W'(cfg_in.interval_seconds) * MS_W'(MS_PER_SECOND);
   assign hold_ms_in     = MS_W'(cfg_in.hold_down_seconds) * MS_W'(MS_PER_SECOND);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.interval_seconds  <= RST_INTERVAL_SECONDS;
         cfg_ff.up_threshold      <= RST_UP_THRESHOLD;
         cfg_ff.down_threshold    <= RST_DOWN_THRESHOLD;
         cfg_ff.hold_down_seconds <= RST_HOLD_DOWN_SECONDS;
         cfg_ff.lease_required    <= RST_LEASE_REQUIRED;
         cfg_ff.start_fail_limit  <= RST_START_FAIL_LIMIT;
         interval_ms_ff           <= MS_W'(RST_INTERVAL_SECONDS) * MS_W'(MS_PER_SECOND);
         hold_ms_ff               <= MS_W'(RST_HOLD_DOWN_SECONDS) * MS_W'(MS_PER_SECOND);
      end else begin
         cfg_ff         <= cfg_in;
         interval_ms_ff <= interval_ms_in;
         hold_ms_ff     <= hold_ms_in;
      end
   end

   assign cfg         = cfg_ff;
   assign interval_ms = interval_ms_ff;
   assign hold_ms     = hold_ms_ff;

endmodule

### sv/lpvt_table.sv
// ----------------------------------------------------------------------------
// lpvt_table: entry store
// Synchronous single-port-read, single-port-write memory of entry records
// with a registered read. A valid bit per entry makes entries that
// were never written since reset read as all zero.
// ----------------------------------------------------------------------------
module lpvt_table #(
   parameter int unsigned ENTRIES = 16,
   parameter int unsigned IDX_W   = 4,
   parameter int unsigned REC_W   = 128
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             rd_en,
   input  logic [IDX_W-1:0] rd_addr,
   output logic [REC_W-1:0] rd_data,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  logic [REC_W-1:0] wr_data
);

   logic [REC_W-1:0]   mem [ENTRIES];
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [REC_W-1:0]   rdata_ff;
   logic               rvalid_ff, rvalid_in;

   // Mark an entry valid on its first write
   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   assign rvalid_in = rd_en ? valid_ff[rd_addr] : rvalid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         rvalid_ff <= rvalid_in;
      end
   end

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   // Never-written entries read as reset state
   assign rd_data = rvalid_ff ? rdata_ff : '0;

endmodule

### sv/lpvt_update.sv
// ----------------------------------------------------------------------------
// lpvt_update: entry update logic
// Takes the entry record read from the store and the registered request,
// applies the due check, lease gate, run counters, set-aside and hold-down
// rules, and returns the record to write back and the response.
// ----------------------------------------------------------------------------
module lpvt_update #(
   parameter int unsigned RUN_WIDTH = 8,
   parameter int unsigned REC_W     = 6 + 2 * 48 + 3 * 8
) (
   input  logic                          in_range,
   input  logic                          opcode,
   input  logic [lpvt_pkg::TIME_W-1:0]   now_ms,
   input  logic [lpvt_pkg::CODE_W-1:0]   result_code,
   input  logic                          dhcp_mode,
   input  logic                          has_lease,
   input  logic [lpvt_pkg::TIME_W-1:0]   due_sum,
   input  logic [lpvt_pkg::TIME_W-1:0]   dwell_sum,
   input  lpvt_pkg::lpvt_cfg_type        cfg,
   input  logic [REC_W-1:0]              rd_rec,
   output logic                          wr_en,
   output logic [REC_W-1:0]              wr_rec,
   output lpvt_pkg::lpvt_rsp_type        rsp
);
   import lpvt_pkg::*;

   localparam int unsigned CMP_W = (RUN_WIDTH > THRESHOLD_W) ? RUN_WIDTH : THRESHOLD_W;
   localparam logic [RUN_WIDTH-1:0] RUN_MAX = '1;

   lpvt_flags_type       cur_flags, nxt_flags;
   logic [TIME_W-1:0]    cur_due, cur_dwell, nxt_due, nxt_dwell;
   logic [RUN_WIDTH-1:0] cur_srun, cur_frun, cur_sfrun;
   logic [RUN_WIDTH-1:0] nxt_srun, nxt_frun, nxt_sfrun;
   logic [RUN_WIDTH-1:0] bump_srun, bump_frun, bump_sfrun;
   logic                 is_due, held, lease_fail;

   // Unpack the record
   assign cur_flags = lpvt_flags_type'(rd_rec[REC_W-1 -: FLAGS_W]);
   assign cur_due   = rd_rec[3*RUN_WIDTH+2*TIME_W-1 -: TIME_W];
   assign cur_dwell = rd_rec[3*RUN_WIDTH+TIME_W-1 -: TIME_W];
   assign cur_srun  = rd_rec[3*RUN_WIDTH-1 -: RUN_WIDTH];
   assign cur_frun  = rd_rec[2*RUN_WIDTH-1 -: RUN_WIDTH];
   assign cur_sfrun = rd_rec[RUN_WIDTH-1:0];

   // Saturating run increments
   assign bump_srun  = (cur_srun  == RUN_MAX) ? RUN_MAX : cur_srun  + 1'b1;
   assign bump_frun  = (cur_frun  == RUN_MAX) ? RUN_MAX : cur_frun  + 1'b1;
   assign bump_sfrun = (cur_sfrun == RUN_MAX) ? RUN_MAX : cur_sfrun + 1'b1;

   // Time checks against the stored deadlines
   assign is_due     = !(cur_flags.due_armed && (now_ms < cur_due));
   assign held       = cur_flags.dwell_armed && (now_ms < cur_dwell);
   assign lease_fail = cfg.lease_required && dhcp_mode && !has_lease;

   always_comb begin
      nxt_flags = cur_flags;
      nxt_due   = cur_due;
      nxt_dwell = cur_dwell;
      nxt_srun  = cur_srun;
      nxt_frun  = cur_frun;
      nxt_sfrun = cur_sfrun;
      wr_en     = 1'b0;
      rsp       = '0;
      rsp.cause = CAUSE_SKIPPED;

      if (!in_range) begin
         // Out of table: leave everything, report skip
         wr_en = 1'b0;
      end else if (opcode == OP_FORGET) begin
         // Drop the entry
         wr_en       = 1'b1;
         rsp.changed = cur_flags.present;
         nxt_flags   = '0;
         nxt_due     = '0;
         nxt_dwell   = '0;
         nxt_srun    = '0;
         nxt_frun    = '0;
         nxt_sfrun   = '0;
      end else begin
         wr_en             = 1'b1;
         nxt_flags.present = 1'b1;
         if (is_due) begin
            // Rearm the interval
            nxt_flags.due_armed = 1'b1;
            nxt_due             = due_sum;
            if (!cur_flags.aside) begin
               rsp.accepted = 1'b1;
               priority if (!lease_fail && (result_code == RC_NOT_STARTED)) begin
                  // Probe could not start: count toward set-aside
                  rsp.cause = CAUSE_NOT_STARTED;
                  nxt_sfrun = bump_sfrun;
                  if (CMP_W'(bump_sfrun) >= CMP_W'(cfg.start_fail_limit)) begin
                     nxt_flags.aside = 1'b1;
                     if (cur_flags.verdict_has) begin
                        nxt_flags.verdict_has = 1'b0;
                        nxt_flags.verdict_val = 1'b0;
                        rsp.changed           = 1'b1;
                     end
                  end
               end else if (!lease_fail && (result_code == RC_OK)) begin
                  // Success run
                  rsp.cause = CAUSE_OK;
                  nxt_sfrun = '0;
                  nxt_frun  = '0;
                  nxt_srun  = bump_srun;
                  if (!held && (CMP_W'(bump_srun) >= CMP_W'(cfg.up_threshold)) &&
                      !(cur_flags.verdict_has && cur_flags.verdict_val)) begin
                     nxt_flags.verdict_has = 1'b1;
                     nxt_flags.verdict_val = 1'b1;
                     nxt_flags.dwell_armed = (cfg.hold_down_seconds != '0);
                     nxt_dwell             = (cfg.hold_down_seconds != '0) ? dwell_sum : '0;
                     rsp.changed           = 1'b1;
                  end
               end else begin
                  // Failure run, including lease gate and unused code
                  rsp.cause = lease_fail ? CAUSE_NO_LEASE : CAUSE_FAILED;
                  nxt_sfrun = '0;
                  nxt_srun  = '0;
                  nxt_frun  = bump_frun;
                  if (!held && (CMP_W'(bump_frun) >= CMP_W'(cfg.down_threshold)) &&
                      !(cur_flags.verdict_has && !cur_flags.verdict_val)) begin
                     nxt_flags.verdict_has = 1'b1;
                     nxt_flags.verdict_val = 1'b0;
                     nxt_flags.dwell_armed = (cfg.hold_down_seconds != '0);
                     nxt_dwell             = (cfg.hold_down_seconds != '0) ? dwell_sum : '0;
                     rsp.changed           = 1'b1;
                  end
               end
            end
         end
      end

      // Report the entry state after the request
      if (in_range) begin
         rsp.verdict_known = nxt_flags.verdict_has;
         rsp.verdict_up    = nxt_flags.verdict_val;
         rsp.is_set_aside  = nxt_flags.aside;
      end
   end

   // Pack the record
   assign wr_rec = {nxt_flags, nxt_due, nxt_dwell, nxt_srun, nxt_frun, nxt_sfrun};

endmodule
